FILE: hw/rtl/ase_pkg.sv
// ase_pkg: shared constants and controller/datapath interface types
// for the array statistics engine
// no dependencies
package ase_pkg;

  // set geometry
  localparam int SET_SIZE    = 64;
  localparam int SAMPLE_BITS = 8;

  // fixed port field widths
  localparam int FIELD_W = 8;
  localparam int CNT_W   = 7;
  localparam int POS_W   = 6;

  // derived widths
  localparam int IDX_W     = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
  localparam int LOAD_W    = $clog2(SET_SIZE + 1);
  localparam int SUM_W     = 14;
  localparam int CNT_DEPTH = 2 ** SAMPLE_BITS;
  localparam int CMP_W     = FIELD_W + 1;

  localparam logic [FIELD_W-1:0] WINDOW_RESET = FIELD_W'(4);

  // commands from the controller
  typedef struct packed {
    logic load;         // request accepted this cycle
    logic cnt_inc;      // write back incremented histogram count
    logic clr_step;     // histogram clearing sweep after reset
    logic mean_load;    // latch the mean from the running sum
    logic mode_issue;   // issue one read of the mode pass
    logic match_issue;  // issue one read of the match pass
    logic finish;       // emit closing result and clear the set
  } cmd_t;

  // status back to the controller
  typedef struct packed {
    logic clr_last;
    logic set_full;
    logic idx_last;
  } status_t;

endpackage

FILE: hw/rtl/ase_ctrl.sv
// ase_ctrl: sequencer of the array statistics engine
// uses ase_pkg (cmd_t, status_t)
module ase_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  ase_pkg::status_t status_i,
  output ase_pkg::cmd_t    cmd_o,
  output logic             busy_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_LOAD_UPD,
    ST_MODE,
    ST_MODE_D1,
    ST_MODE_D2,
    ST_MATCH,
    ST_MATCH_END,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:     if (status_i.clr_last) state_d = ST_LOAD;
      ST_LOAD:      if (start_i) state_d = ST_LOAD_UPD;
      ST_LOAD_UPD:  state_d = status_i.set_full ? ST_MODE : ST_LOAD;
      ST_MODE:      if (status_i.idx_last) state_d = ST_MODE_D1;
      ST_MODE_D1:   state_d = ST_MODE_D2;
      ST_MODE_D2:   state_d = ST_MATCH;
      ST_MATCH:     if (status_i.idx_last) state_d = ST_MATCH_END;
      ST_MATCH_END: state_d = ST_FINISH;
      ST_FINISH:    state_d = ST_LOAD;
      default:      state_d = ST_CLEAR;
    endcase
  end

  // commands per state
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_CLEAR:    cmd_o.clr_step = 1'b1;
      ST_LOAD:     cmd_o.load = start_i;
      ST_LOAD_UPD: begin
        cmd_o.cnt_inc   = 1'b1;
        cmd_o.mean_load = status_i.set_full;
      end
      ST_MODE:     cmd_o.mode_issue = 1'b1;
      ST_MATCH:    cmd_o.match_issue = 1'b1;
      ST_FINISH:   cmd_o.finish = 1'b1;
      default:     cmd_o = '0;
    endcase
  end

  // state and registered busy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_LOAD);
    end
  end

  assign busy_o = busy_q;

endmodule

FILE: hw/rtl/ase_datapath.sv
// ase_datapath: sample store, value histogram, mean, mode and match passes
// uses ase_pkg (widths, cmd_t, status_t)
module ase_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ase_pkg::cmd_t               cmd_i,
  output ase_pkg::status_t            status_o,
  input  logic [ase_pkg::FIELD_W-1:0] sample_i,
  input  logic                        cfg_valid_i,
  input  logic [ase_pkg::FIELD_W-1:0] cfg_window_i,
  output logic                        result_valid_o,
  output logic [ase_pkg::FIELD_W-1:0] mean_o,
  output logic [ase_pkg::FIELD_W-1:0] maximum_o,
  output logic [ase_pkg::FIELD_W-1:0] minimum_o,
  output logic [ase_pkg::FIELD_W-1:0] mode_value_o,
  output logic [ase_pkg::CNT_W-1:0]   mode_count_o,
  output logic                        match_valid_o,
  output logic [ase_pkg::FIELD_W-1:0] match_value_o,
  output logic [ase_pkg::POS_W-1:0]   match_position_o,
  output logic                        last_o
);

  localparam int SB      = ase_pkg::SAMPLE_BITS;
  localparam int FW      = ase_pkg::FIELD_W;
  localparam int CW      = ase_pkg::CNT_W;
  localparam int IW      = ase_pkg::IDX_W;
  localparam int SW      = ase_pkg::SUM_W;
  localparam int CMP_W_L = ase_pkg::CMP_W;

  // memories
  logic [SB-1:0] store_mem [ase_pkg::SET_SIZE];
  logic [CW-1:0] cnt_mem   [ase_pkg::CNT_DEPTH];

  logic [FW-1:0]             window_q;
  logic [ase_pkg::LOAD_W-1:0] load_q;
  logic [SW-1:0]             sum_q;
  logic [FW-1:0]             max_q, min_q;
  logic [IW-1:0]             idx_q;
  logic [SB-1:0]             clr_q;
  logic [SB-1:0]             store_rd_q;
  logic [CW-1:0]             cnt_rd_q;
  logic [SB-1:0]             upd_addr_q;
  logic [FW-1:0]             mean_q;
  logic                      v1_q, v2_q, m1_q;
  logic [SB-1:0]             val2_q;
  logic [IW-1:0]             pos1_q;
  logic [SB-1:0]             best_val_q;
  logic [CW-1:0]             best_cnt_q;
  logic                      pend_q;
  logic [SB-1:0]             pend_val_q;
  logic [IW-1:0]             pend_pos_q;

  logic [SB-1:0] s;
  logic [SB-1:0] cnt_ra, cnt_wa;
  logic [CW-1:0] cnt_wd;
  logic          cnt_we;
  logic [CMP_W_L-1:0] sv_ext, mean_ext, win_ext;
  logic          hit;
  logic          emit_mid;

  assign s = SB'(sample_i);

  // status
  assign status_o.clr_last = (clr_q == {SB{1'b1}});
  assign status_o.set_full = (load_q == ase_pkg::LOAD_W'(ase_pkg::SET_SIZE));
  assign status_o.idx_last = (idx_q == IW'(ase_pkg::SET_SIZE - 1));

  // sample store: write on load, read by index
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      store_mem[load_q[IW-1:0]] <= s;
    end
    store_rd_q <= store_mem[idx_q];
  end

  // histogram port selection
  assign cnt_ra = cmd_i.load ? s : store_rd_q;

  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = clr_q;
    cnt_wd = '0;
    if (cmd_i.clr_step) begin
      cnt_we = 1'b1;
    end else if (cmd_i.cnt_inc) begin
      cnt_we = 1'b1;
      cnt_wa = upd_addr_q;
      cnt_wd = cnt_rd_q + CW'(1);
    end else if (m1_q) begin
      // match pass zeroes every value of the set for the next one
      cnt_we = 1'b1;
      cnt_wa = store_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_q <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      upd_addr_q <= s;
    end
  end

  // window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= ase_pkg::WINDOW_RESET;
    end else if (cfg_valid_i) begin
      window_q <= cfg_window_i;
    end
  end

  // running statistics and load index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
      sum_q  <= '0;
      max_q  <= '0;
      min_q  <= '1;
    end else if (cmd_i.finish) begin
      load_q <= '0;
      sum_q  <= '0;
      max_q  <= '0;
      min_q  <= '1;
    end else if (cmd_i.load) begin
      load_q <= load_q + ase_pkg::LOAD_W'(1);
      sum_q  <= sum_q + SW'(s);
      if (FW'(s) > max_q) max_q <= FW'(s);
      if (FW'(s) < min_q) min_q <= FW'(s);
    end
  end

  // pass index and clearing sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.mode_issue || cmd_i.match_issue) begin
        idx_q <= status_o.idx_last ? '0 : idx_q + IW'(1);
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + SB'(1);
      end
    end
  end

  // mean of the full set, set size is a power of two
  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_load) begin
      mean_q <= FW'(sum_q / SW'(ase_pkg::SET_SIZE));
    end
  end

  // mode pass: store read, histogram read, compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      m1_q       <= 1'b0;
      best_cnt_q <= '0;
    end else begin
      v1_q <= cmd_i.mode_issue;
      v2_q <= v1_q;
      m1_q <= cmd_i.match_issue;
      if (cmd_i.finish) begin
        best_cnt_q <= '0;
      end else if (v2_q && (cnt_rd_q > best_cnt_q)) begin
        best_cnt_q <= cnt_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val2_q <= store_rd_q;
    pos1_q <= idx_q;
    if (v2_q && (cnt_rd_q > best_cnt_q)) begin
      best_val_q <= val2_q;
    end
  end

  // open window test around the mean
  assign sv_ext   = CMP_W_L'(store_rd_q);
  assign mean_ext = CMP_W_L'(mean_q);
  assign win_ext  = CMP_W_L'(window_q);
  assign hit      = ((sv_ext + win_ext) > mean_ext) && (sv_ext < (mean_ext + win_ext));
  assign emit_mid = m1_q && hit && pend_q;

  // one hit held back so the final result can carry last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (cmd_i.finish) begin
      pend_q <= 1'b0;
    end else if (m1_q && hit) begin
      pend_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m1_q && hit) begin
      pend_val_q <= store_rd_q;
      pend_pos_q <= pos1_q;
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= emit_mid || cmd_i.finish;
    end
  end

  // result fields
  always_ff @(posedge clk_i) begin
    if (emit_mid || cmd_i.finish) begin
      mean_o           <= mean_q;
      maximum_o        <= max_q;
      minimum_o        <= min_q;
      mode_value_o     <= FW'(best_val_q);
      mode_count_o     <= best_cnt_q;
      match_valid_o    <= pend_q;
      match_value_o    <= pend_q ? FW'(pend_val_q) : '0;
      match_position_o <= pend_q ? ase_pkg::POS_W'(pend_pos_q) : '0;
      last_o           <= cmd_i.finish;
    end
  end

endmodule

FILE: hw/rtl/array_statistics_engine.sv
// array_statistics_engine: top level, mean/min/max/mode and window matches
// uses ase_pkg, ase_ctrl, ase_datapath
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+------------------------------------
//  request   | start_i, busy_o              | sample_i
//  config    | cfg_valid_i, cfg_ready_o     | cfg_window_i
//  result    | result_valid_o (strobe)      | mean_o maximum_o minimum_o
//            |                              | mode_value_o mode_count_o
//            |                              | match_valid_o match_value_o
//            |                              | match_position_o last_o
//
// each sample is stored, then its histogram count updated before the next is taken
// the mean is latched with the last sample update; then the mode pass and the
// match pass, which ends with the closing result, each read the set of 64
// results leave at most one per cycle during the match pass and once at its end
// after reset the 256-entry histogram is swept to zero with busy high
// results cannot be stalled; config writes are always taken
module array_statistics_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [ase_pkg::FIELD_W-1:0] sample_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ase_pkg::FIELD_W-1:0] cfg_window_i,
  output logic                        result_valid_o,
  output logic [ase_pkg::FIELD_W-1:0] mean_o,
  output logic [ase_pkg::FIELD_W-1:0] maximum_o,
  output logic [ase_pkg::FIELD_W-1:0] minimum_o,
  output logic [ase_pkg::FIELD_W-1:0] mode_value_o,
  output logic [ase_pkg::CNT_W-1:0]   mode_count_o,
  output logic                        match_valid_o,
  output logic [ase_pkg::FIELD_W-1:0] match_value_o,
  output logic [ase_pkg::POS_W-1:0]   match_position_o,
  output logic                        last_o
);

  ase_pkg::cmd_t    cmd;
  ase_pkg::status_t status;

  // window register takes every write
  assign cfg_ready_o = 1'b1;

  ase_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  ase_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .sample_i         (sample_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_window_i     (cfg_window_i),
    .result_valid_o   (result_valid_o),
    .mean_o           (mean_o),
    .maximum_o        (maximum_o),
    .minimum_o        (minimum_o),
    .mode_value_o     (mode_value_o),
    .mode_count_o     (mode_count_o),
    .match_valid_o    (match_valid_o),
    .match_value_o    (match_value_o),
    .match_position_o (match_position_o),
    .last_o           (last_o)
  );

endmodule

FILE: bench/tb_array_statistics_engine.sv
// tb_array_statistics_engine: self-checking bench for the array statistics engine
// drives sample requests and window writes, predicts mean/max/min/mode and window matches
// depends on ase_pkg and array_statistics_engine
`timescale 1ns / 100ps

module tb_array_statistics_engine;
  import ase_pkg::*;

  localparam int SETTLE_CYCLES = 32;
  localparam int TAIL_CYCLES   = 300;
  localparam int MAX_REPORTS   = 10;

  // shape of the sample content of a random set
  typedef enum int {
    SPREAD_UNIFORM,
    SPREAD_CLUSTER,
    SPREAD_FEW,
    SPREAD_SPLIT
  } spread_e;

  typedef struct packed {
    logic [FIELD_W-1:0] mean;
    logic [FIELD_W-1:0] maximum;
    logic [FIELD_W-1:0] minimum;
    logic [FIELD_W-1:0] mode_value;
    logic [CNT_W-1:0]   mode_count;
    logic               match_valid;
    logic [FIELD_W-1:0] match_value;
    logic [POS_W-1:0]   match_position;
    logic               last;
  } stats_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic [FIELD_W-1:0] sample_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic [FIELD_W-1:0] cfg_window_i = '0;
  logic               busy_o;
  logic               cfg_ready_o;
  logic               result_valid_o;
  logic [FIELD_W-1:0] mean_o;
  logic [FIELD_W-1:0] maximum_o;
  logic [FIELD_W-1:0] minimum_o;
  logic [FIELD_W-1:0] mode_value_o;
  logic [CNT_W-1:0]   mode_count_o;
  logic               match_valid_o;
  logic [FIELD_W-1:0] match_value_o;
  logic [POS_W-1:0]   match_position_o;
  logic               last_o;

  // samples waiting to be sent and statistics results still due
  logic [FIELD_W-1:0] sample_backlog_q[$];
  stats_result_t      stats_due_q[$];

  // predictor copy of the set and the window register
  logic [FIELD_W-1:0] set_store[SET_SIZE];
  int                 load_cnt = 0;
  logic [SUM_W-1:0]   set_sum = '0;
  logic [FIELD_W-1:0] set_max = '0;
  logic [FIELD_W-1:0] set_min = '1;
  logic [FIELD_W-1:0] window_q = WINDOW_RESET;

  logic               taken = 1'b0;
  int                 gap_left = 0;
  int                 gap_max = 0;
  int                 fail_cnt = 0;

  array_statistics_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .sample_i        (sample_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_window_i    (cfg_window_i),
    .result_valid_o  (result_valid_o),
    .mean_o          (mean_o),
    .maximum_o       (maximum_o),
    .minimum_o       (minimum_o),
    .mode_value_o    (mode_value_o),
    .mode_count_o    (mode_count_o),
    .match_valid_o   (match_valid_o),
    .match_value_o   (match_value_o),
    .match_position_o(match_position_o),
    .last_o          (last_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #100000;
    $display("Regression FAIL");
    $finish;
  end

  // fold one sample into the set; a full set yields its match results
  function automatic void absorb_sample(input logic [FIELD_W-1:0] s);
    int                 mean_v;
    int                 lo;
    int                 hi;
    int                 hits;
    int                 sent;
    int                 cnt;
    int                 best_cnt;
    logic [FIELD_W-1:0] best_val;
    stats_result_t      r;
    set_store[load_cnt] = s;
    set_sum = set_sum + SUM_W'(s);
    if (s > set_max) set_max = s;
    if (s < set_min) set_min = s;
    load_cnt++;
    if (load_cnt < SET_SIZE) return;

    mean_v = int'(set_sum) / SET_SIZE;
    // most frequent value, strict compare keeps the earliest on a tie
    best_cnt = 0;
    best_val = '0;
    for (int i = 0; i < SET_SIZE; i++) begin
      cnt = 0;
      for (int j = 0; j < SET_SIZE; j++)
        if (set_store[j] == set_store[i]) cnt++;
      if (cnt > best_cnt) begin
        best_cnt = cnt;
        best_val = set_store[i];
      end
    end

    // open window around the mean, lower bound may go negative
    lo = mean_v - int'(window_q);
    hi = mean_v + int'(window_q);
    hits = 0;
    for (int i = 0; i < SET_SIZE; i++)
      if (int'(set_store[i]) > lo && int'(set_store[i]) < hi) hits++;

    r.mean           = FIELD_W'(mean_v);
    r.maximum        = set_max;
    r.minimum        = set_min;
    r.mode_value     = best_val;
    r.mode_count     = CNT_W'(best_cnt);
    r.match_valid    = 1'b0;
    r.match_value    = '0;
    r.match_position = '0;
    r.last           = 1'b1;
    if (hits == 0) begin
      stats_due_q.push_back(r);
    end else begin
      sent = 0;
      for (int i = 0; i < SET_SIZE; i++) begin
        if (int'(set_store[i]) > lo && int'(set_store[i]) < hi) begin
          sent++;
          r.match_valid    = 1'b1;
          r.match_value    = set_store[i];
          r.match_position = POS_W'(i);
          r.last           = (sent == hits);
          stats_due_q.push_back(r);
        end
      end
    end

    // next set starts from the reset values
    load_cnt = 0;
    set_sum  = '0;
    set_max  = '0;
    set_min  = '1;
  endfunction

  function automatic string show_result(input stats_result_t r);
    return $sformatf("mean %0d max %0d min %0d mode %0d x%0d match %0b val %0d pos %0d last %0b",
                     r.mean, r.maximum, r.minimum, r.mode_value, r.mode_count,
                     r.match_valid, r.match_value, r.match_position, r.last);
  endfunction

  function automatic void note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // request acceptance and result checking at the rising edge
  always @(posedge clk_i) begin : watch
    stats_result_t got;
    stats_result_t want;
    if (!rst_ni) begin
      taken <= 1'b0;
    end else begin
      taken <= start_i && !busy_o;
      if (start_i && !busy_o) absorb_sample(sample_i);
      if (result_valid_o) begin
        got = '{mean_o, maximum_o, minimum_o, mode_value_o, mode_count_o,
                match_valid_o, match_value_o, match_position_o, last_o};
        if (stats_due_q.size() == 0) begin
          note_failure($sformatf("%0t: result with none due: %s", $realtime, show_result(got)));
        end else begin
          want = stats_due_q.pop_front();
          if (got !== want)
            note_failure($sformatf("%0t: mismatch\n  expected %s\n  actual   %s",
                                   $realtime, show_result(want), show_result(got)));
        end
      end
    end
  end

  // request driver, holds start until taken and waits a random gap between requests
  always @(negedge clk_i) begin : feed
    if (!rst_ni) begin
      start_i  <= 1'b0;
      sample_i <= '0;
      gap_left <= 0;
    end else if (!(start_i && !taken)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start_i  <= 1'b0;
      end else if (sample_backlog_q.size() != 0) begin
        sample_i <= sample_backlog_q.pop_front();
        start_i  <= 1'b1;
        gap_left <= $urandom_range(0, gap_max);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // hold off until every sample is taken, every result is in and the block is quiet
  task automatic drain_block();
    while (sample_backlog_q.size() != 0 || start_i) @(posedge clk_i);
    while (stats_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [FIELD_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i  <= 1'b1;
    cfg_window_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    window_q = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [FIELD_W-1:0] pool[4];
    spread_e            shape;
    int                 center;
    int                 v;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // all distinct samples with both extremes, window at its reset value
    gap_max = 0;
    for (int i = 0; i < SET_SIZE - 1; i++) sample_backlog_q.push_back(FIELD_W'(i * 4));
    sample_backlog_q.push_back(8'hFF);
    drain_block();

    // empty window and a two-way mode tie, earlier value first
    write_window(8'd0);
    gap_max = 8;
    for (int i = 0; i < SET_SIZE; i++) sample_backlog_q.push_back((i % 2) ? 8'd9 : 8'd200);
    drain_block();

    // widest window over all zeros, lower bound below zero, every sample matches
    write_window(8'hFF);
    gap_max = 3;
    for (int i = 0; i < SET_SIZE; i++) sample_backlog_q.push_back(8'd0);
    drain_block();

    // random sets, one of each shape
    for (int k = 0; k < 4; k++) begin
      shape  = spread_e'(k);
      center = $urandom_range(0, 255);
      for (int i = 0; i < 4; i++) pool[i] = FIELD_W'($urandom_range(0, 255));
      case (shape)
        SPREAD_UNIFORM: write_window(FIELD_W'($urandom_range(0, 255)));
        SPREAD_CLUSTER: write_window(FIELD_W'($urandom_range(1, 12)));
        SPREAD_FEW:     write_window(FIELD_W'($urandom_range(0, 64)));
        default:        write_window(FIELD_W'($urandom_range(0, 40)));
      endcase
      gap_max = (k % 2) ? 8 : 0;
      for (int i = 0; i < SET_SIZE; i++) begin
        case (shape)
          SPREAD_UNIFORM: v = $urandom_range(0, 255);
          SPREAD_CLUSTER: begin
            v = center + $urandom_range(0, 12) - 6;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
          end
          SPREAD_FEW:     v = pool[$urandom_range(0, 3)];
          default:        v = $urandom_range(0, 1) ? $urandom_range(0, 15)
                                                   : $urandom_range(240, 255);
        endcase
        sample_backlog_q.push_back(FIELD_W'(v));
      end
      drain_block();
    end

    // quiet tail, then anything still due is a failure
    repeat (TAIL_CYCLES) @(posedge clk_i);
    fail_cnt += stats_due_q.size();
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ase_pkg.sv
hw/rtl/ase_ctrl.sv
hw/rtl/ase_datapath.sv
hw/rtl/array_statistics_engine.sv
bench/tb_array_statistics_engine.sv
